// ===== design/pti_pkg.sv =====
// Package for the pair-to-index table: widths, opcodes, defaults and the
// sequencer state type. No dependencies; every other file but pti_ram uses it.
`timescale 1ns / 1ps
`default_nettype none

package pti_pkg;

  // Widths of the beat fields at the ports.
  localparam int ID_IN_W = 16;
  localparam int DV_W    = 8;

  // Default configuration of the table.
  localparam int ENTRIES_DEF  = 256;
  localparam int ID_WIDTH_DEF = 16;

  // Request opcodes.
  localparam logic OP_LOOKUP_INSERT = 1'b0;
  localparam logic OP_FIND_ONLY     = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } seq_state_e;

endpackage : pti_pkg

`default_nettype wire

// ===== design/pti_if.sv =====
// Valid/ready channel interfaces for the request and result beats.
// Depends on pti_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pti_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [pti_pkg::ID_IN_W-1:0] press_id;
  logic [pti_pkg::ID_IN_W-1:0] release_id;

  modport source (output valid, input ready, output opcode, output press_id,
                  output release_id);
  modport sink   (input valid, output ready, input opcode, input press_id,
                  input release_id);
endinterface : pti_in_if

interface pti_out_if;
  logic                     valid;
  logic                     ready;
  logic [pti_pkg::DV_W-1:0] drawing_value;
  logic                     table_full;

  modport source (output valid, input ready, output drawing_value,
                  output table_full);
  modport sink   (input valid, output ready, input drawing_value,
                  input table_full);
endinterface : pti_out_if

`default_nettype wire

// ===== design/pair_to_index_table_core.sv =====
// A request is answered once the scan reaches its pair, or after all stored
// pairs on a miss; (0,0) is answered without a scan. The block takes one
// request at a time; the single RAM read port scans one pair per cycle.
// Reset (rst_ni low, asynchronous) empties the table and the result register.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the pair-to-index table. It maps a pair of feedback ids to a
// small index. The stored pairs live in a RAM; a sequencer scans entries
// 1..fill count with one comparator, one entry per cycle, and appends the
// pair at the next free index on a lookup-or-insert miss while room remains.
// Entry 0 always stands for the inactive pair (0,0); it is never stored in
// the RAM, and the sequencer answers that pair directly. Because every entry
// at or below the fill count has been written, reset only needs to clear
// the fill count and no clearing pass runs over the RAM.
//
// Depends on pti_pkg, pti_if.sv, pti_ram and pti_seq.
module pair_to_index_table_core #(
  parameter int ENTRIES  = pti_pkg::ENTRIES_DEF,
  parameter int ID_WIDTH = pti_pkg::ID_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pti_in_if.sink    in_i,
  pti_out_if.source out_o
);

  localparam int IW = $clog2(ENTRIES);

  // RAM port signals between the sequencer and the pair store.
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [2*ID_WIDTH-1:0] ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [2*ID_WIDTH-1:0] ram_rdata;

  // The sequencer owns both handshakes and the fill count.
  pti_seq #(
    .ENTRIES  (ENTRIES),
    .ID_WIDTH (ID_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Each word holds the press id in the upper half and the release id in
  // the lower half.
  pti_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (2 * ID_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule : pair_to_index_table_core

`default_nettype wire

// ===== design/pti_ram.sv =====
// Simple dual-port pair store: one write port, one read port with
// registered read data. Standalone; no package use.
`timescale 1ns / 1ps
`default_nettype none

module pti_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : pti_ram

`default_nettype wire

// ===== design/pti_seq.sv =====
// Search sequencer: walks the stored pairs through the RAM read port with
// one shared comparator, appends on a lookup-or-insert miss and holds the result register.
// Depends on pti_pkg and on the channel interfaces in pti_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module pti_seq #(
  parameter int ENTRIES  = pti_pkg::ENTRIES_DEF,
  parameter int ID_WIDTH = pti_pkg::ID_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  pti_in_if.sink                           in_i,
  pti_out_if.source                        out_o,
  output logic                             ram_we_o,
  output logic [$clog2(ENTRIES)-1:0]       ram_waddr_o,
  output logic [2*ID_WIDTH-1:0]            ram_wdata_o,
  output logic [$clog2(ENTRIES)-1:0]       ram_raddr_o,
  input  wire logic [2*ID_WIDTH-1:0]       ram_rdata_i
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int InW  = pti_pkg::ID_IN_W;
  localparam int ExtW = (ID_WIDTH > InW) ? ID_WIDTH : InW;
  localparam int DvW  = pti_pkg::DV_W;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  pti_pkg::seq_state_e state_q, state_d;

  logic                op_q;
  logic [ID_WIDTH-1:0] press_q, release_q;
  logic [IW-1:0]       idx_q, cmp_idx_q, count_q, res_val_q;
  logic                cmp_vld_q, res_full_q;
  logic                out_valid_q, out_full_q;
  logic [DvW-1:0]      out_val_q;

  logic [ExtW-1:0]     press_ext, release_ext;
  logic [ID_WIDTH-1:0] press_in, release_in;
  logic                zero_pair, hit, miss, room;

  // Control decoded from the state.
  logic ld_item, iss, fin_hit, fin_miss, ld_out;

  assign press_ext   = ExtW'(in_i.press_id);
  assign release_ext = ExtW'(in_i.release_id);
  assign press_in    = press_ext[ID_WIDTH-1:0];
  assign release_in  = release_ext[ID_WIDTH-1:0];
  assign zero_pair   = (press_in == '0) && (release_in == '0);

  // The shared comparator looks at the word read in the previous cycle.
  assign hit  = cmp_vld_q && (ram_rdata_i == {press_q, release_q});
  assign miss = (cmp_vld_q && !hit && (cmp_idx_q == count_q)) ||
                (!cmp_vld_q && (idx_q > count_q));
  assign room = (count_q != LastIdx);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pti_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = zero_pair ? pti_pkg::ST_DONE : pti_pkg::ST_SEARCH;
        end
      end
      pti_pkg::ST_SEARCH: begin
        if (hit || miss) begin
          state_d = pti_pkg::ST_DONE;
        end
      end
      pti_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = pti_pkg::ST_IDLE;
        end
      end
      default: state_d = pti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    ld_item    = 1'b0;
    iss        = 1'b0;
    fin_hit    = 1'b0;
    fin_miss   = 1'b0;
    ld_out     = 1'b0;
    case (state_q)
      pti_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        ld_item    = in_i.valid;
      end
      pti_pkg::ST_SEARCH: begin
        fin_hit  = hit;
        fin_miss = miss;
        iss      = !(hit || miss) && (idx_q <= count_q);
      end
      pti_pkg::ST_DONE: begin
        ld_out = !out_valid_q || out_o.ready;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  assign ram_raddr_o = idx_q;
  assign ram_we_o    = fin_miss && (op_q == pti_pkg::OP_LOOKUP_INSERT) && room;
  assign ram_waddr_o = count_q + IW'(1);
  assign ram_wdata_o = {press_q, release_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pti_pkg::ST_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= iss;
      if (ram_we_o) begin
        count_q <= count_q + IW'(1);
      end
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_item) begin
      op_q       <= in_i.opcode;
      press_q    <= press_in;
      release_q  <= release_in;
      idx_q      <= IW'(1);
      res_val_q  <= '0;
      res_full_q <= 1'b0;
    end else if (iss && (idx_q != count_q)) begin
      idx_q <= idx_q + IW'(1);
    end
    cmp_idx_q <= idx_q;
    if (fin_hit) begin
      res_val_q  <= cmp_idx_q;
      res_full_q <= 1'b0;
    end else if (fin_miss) begin
      if (op_q == pti_pkg::OP_FIND_ONLY) begin
        res_val_q  <= '0;
        res_full_q <= 1'b0;
      end else if (!room) begin
        res_val_q  <= '0;
        res_full_q <= 1'b1;
      end else begin
        res_val_q  <= count_q + IW'(1);
        res_full_q <= 1'b0;
      end
    end
    if (ld_out) begin
      out_val_q  <= DvW'(res_val_q);
      out_full_q <= res_full_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.drawing_value = out_val_q;
  assign out_o.table_full    = out_full_q;

endmodule : pti_seq

`default_nettype wire

// ===== design/pti_checker.sv =====
// Port-level checker for the pair-to-index table and its bind to the top.
// Depends on pti_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module pti_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic [pti_pkg::DV_W-1:0] drawing_value_i,
  input wire logic                     table_full_i
);

  // A result beat that is not taken stays with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(drawing_value_i) && $stable(table_full_i))
    else $error("result beat changed while stalled");

  // A refused insert never carries an index.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && table_full_i |-> drawing_value_i == '0)
    else $error("table_full with nonzero drawing_value");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // A new result only appears at the end of a request's work.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while idle");

endmodule : pti_checker

bind pair_to_index_table_core pti_checker u_pti_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .drawing_value_i (out_o.drawing_value),
  .table_full_i    (out_o.table_full)
);

`default_nettype wire

// ===== tb/pti_result_checker.sv =====
// Result checker for the pair-to-index table: watches the request and result
// channels, keeps its own copy of the pair table and checks every result beat.
// Depends on pti_pkg and the channel interfaces in pti_if.sv.
`timescale 1ns / 1ps

module pti_result_checker #(
  parameter int ENTRIES  = pti_pkg::ENTRIES_DEF,
  parameter int ID_WIDTH = pti_pkg::ID_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pti_in_if    req_i,
  pti_out_if   res_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   fill_o,
  output int   refused_o
);
  import pti_pkg::*;

  typedef logic [ID_IN_W-1:0] id_t;

  typedef struct packed {
    logic [DV_W-1:0] drawing_value;
    logic            table_full;
  } index_reply_t;

  // Ids narrower than the port keep only their low ID_WIDTH bits.
  localparam id_t ID_MASK = (ID_WIDTH >= ID_IN_W) ? {ID_IN_W{1'b1}} :
                            id_t'((64'd1 << ID_WIDTH) - 1);

  id_t          press_tbl   [ENTRIES];
  id_t          release_tbl [ENTRIES];
  int unsigned  fill_level;
  index_reply_t replies_due [$];
  int           mismatches;
  int           refused;
  int           reply_no;

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t ns] result beat %0d: %s", $time, reply_no, what);
    end
  endfunction

  // Searches entries 0..fill level in ascending order; a lookup-or-insert
  // miss appends the pair unless the table is already full.
  function automatic index_reply_t resolve_pair(logic op, id_t press_raw, id_t release_raw);
    id_t          press;
    id_t          rel;
    index_reply_t reply;
    bit           found;
    int unsigned  slot;
    press = press_raw & ID_MASK;
    rel   = release_raw & ID_MASK;
    reply = '0;
    found = 1'b0;
    slot  = 0;
    for (int unsigned i = 0; i <= fill_level && !found; i++) begin
      if (press_tbl[i] == press && release_tbl[i] == rel) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      reply.drawing_value = DV_W'(slot);
    end else if (op == OP_LOOKUP_INSERT) begin
      if (fill_level >= ENTRIES - 1) begin
        reply.table_full = 1'b1;
      end else begin
        fill_level++;
        press_tbl[fill_level]   = press;
        release_tbl[fill_level] = rel;
        reply.drawing_value     = DV_W'(fill_level);
      end
    end
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    index_reply_t got;
    index_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        press_tbl[i]   = '0;
        release_tbl[i] = '0;
      end
      fill_level = 0;
      replies_due.delete();
      mismatches = 0;
      refused    = 0;
      reply_no   = 0;
    end else begin
      // A result can never belong to a request accepted on the same edge,
      // so results are retired before new requests are predicted.
      if (res_i.valid && res_i.ready) begin
        got = {res_i.drawing_value, res_i.table_full};
        if (got.table_full) refused++;
        if (replies_due.size() == 0) begin
          log_mismatch($sformatf("no request outstanding, got value %0d full %0b",
                                 got.drawing_value, got.table_full));
        end else begin
          want = replies_due.pop_front();
          if (got.drawing_value != want.drawing_value) begin
            log_mismatch($sformatf("drawing_value expected %0d, actual %0d",
                                   want.drawing_value, got.drawing_value));
          end
          if (got.table_full != want.table_full) begin
            log_mismatch($sformatf("table_full expected %0b, actual %0b",
                                   want.table_full, got.table_full));
          end
        end
        reply_no++;
      end
      if (req_i.valid && req_i.ready) begin
        replies_due.push_back(resolve_pair(req_i.opcode, req_i.press_id, req_i.release_id));
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= replies_due.size();
    fill_o       <= fill_level;
    refused_o    <= refused;
  end

endmodule : pti_result_checker

// ===== tb/testbench.sv =====
// Top of the pair-to-index table testbench: clock, reset, request and result
// pacing, and the verdict. Depends on pti_pkg, pti_if.sv, the core and
// pti_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;
  import pti_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;

  // The tail wait at the end covers one full scan of the table after the last
  // result beat.
  localparam int TAIL_CYCLES = ENTRIES_DEF + 8;

  // Slowest plausible run: about 1800 requests, each a full table scan
  // plus long sender gaps and receiver stalls, is well under 10 ms. The
  // limit takes that several times over.
  localparam int RUN_LIMIT_NS = 40_000_000;

  // Corner ids: inactive, transparent, top bit only, all ones.
  localparam logic [ID_IN_W-1:0] CORNER_IDS [4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};

  logic clk_i = 1'b0;
  logic rst_ni;

  pti_in_if  req_if ();
  pti_out_if res_if ();

  int mismatches;
  int pending;
  int fill;
  int refused;

  // Chance, in percent, that the sender or the receiver sits out a cycle.
  int snd_idle_pct = 12;
  int rcv_idle_pct = 77;

  int requests_sent;
  int finds_sent;

  // Every pair ever sent, packed {press, release}; reused to produce hits,
  // repeats and near misses.
  logic [2*ID_IN_W-1:0] pair_pool [$];

  pair_to_index_table_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  pti_result_checker index_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_i       (res_if),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .fill_o      (fill),
    .refused_o   (refused)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // The receiver decides once per cycle, at the falling edge, whether it
  // takes a result beat on the next rising edge.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Presents one request beat and holds it until the core accepts it.
  // Called at a falling edge and returns at the falling edge after the
  // accepting rising edge. While the sender idles, valid stays low; a
  // back-to-back request keeps valid high without dropping it in between.
  task automatic issue_request(input logic op, input logic [ID_IN_W-1:0] press,
                               input logic [ID_IN_W-1:0] rel);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.press_id   <= press;
    req_if.release_id <= rel;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    pair_pool.push_back({press, rel});
    requests_sent++;
    if (op == OP_FIND_ONLY) finds_sent++;
  endtask

  // Stops sending until every predicted result beat has come back.
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One random request. Most reuse earlier pairs so that hits land at every
  // depth of the table; fresh pairs fill it up until inserts are refused;
  // corner ids and single-bit near misses probe the comparator.
  task automatic issue_random();
    logic                 op;
    logic [ID_IN_W-1:0]   press;
    logic [ID_IN_W-1:0]   rel;
    logic [2*ID_IN_W-1:0] pick;
    int                   kind;
    op   = ($urandom_range(99) < 25) ? OP_FIND_ONLY : OP_LOOKUP_INSERT;
    kind = $urandom_range(99);
    pick = pair_pool[$urandom_range(pair_pool.size() - 1)];
    if (kind < 28) begin
      press = ID_IN_W'($urandom);
      rel   = ID_IN_W'($urandom);
    end else if (kind < 33) begin
      press = CORNER_IDS[$urandom_range(3)];
      rel   = CORNER_IDS[$urandom_range(3)];
    end else if (kind < 38) begin
      pick = pick ^ ({{(2*ID_IN_W-1){1'b0}}, 1'b1} << $urandom_range(2*ID_IN_W-1));
      {press, rel} = pick;
    end else begin
      {press, rel} = pick;
    end
    issue_request(op, press, rel);
  endtask

  // A block of random requests under one pacing, followed by a full drain,
  // so the sender pauses with nothing outstanding at every phase boundary.
  task automatic run_phase(input int snd_pct, input int rcv_pct, input int count);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (count) issue_random();
    hold_until_drained();
  endtask

  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_LOOKUP_INSERT;
    req_if.press_id    = '0;
    req_if.release_id  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed opening. The inactive pair answers index 0 for both
    // operations and is never appended; a find on the empty table misses.
    issue_request(OP_LOOKUP_INSERT, 16'h0000, 16'h0000);
    issue_request(OP_FIND_ONLY,     16'h0000, 16'h0000);
    issue_request(OP_FIND_ONLY,     16'h1234, 16'h5678);
    // Extremes of both ids, then the transparent id, fill the first slots.
    issue_request(OP_LOOKUP_INSERT, 16'hFFFF, 16'hFFFF);
    issue_request(OP_LOOKUP_INSERT, 16'h0000, 16'hFFFF);
    issue_request(OP_LOOKUP_INSERT, 16'hFFFF, 16'h0000);
    issue_request(OP_LOOKUP_INSERT, 16'h0001, 16'h0001);
    issue_request(OP_LOOKUP_INSERT, 16'h0000, 16'h0001);
    issue_request(OP_LOOKUP_INSERT, 16'h0001, 16'h0000);
    issue_request(OP_LOOKUP_INSERT, 16'hAAAA, 16'h5555);
    issue_request(OP_LOOKUP_INSERT, 16'h5555, 16'hAAAA);
    // Finds at the first and at the last filled entry, a repeated insert
    // that must hit, and misses that differ from a stored pair by one bit.
    issue_request(OP_FIND_ONLY,     16'hFFFF, 16'hFFFF);
    issue_request(OP_FIND_ONLY,     16'h5555, 16'hAAAA);
    issue_request(OP_LOOKUP_INSERT, 16'hFFFF, 16'hFFFF);
    issue_request(OP_FIND_ONLY,     16'h1234, 16'h5678);
    issue_request(OP_LOOKUP_INSERT, 16'h0000, 16'h0000);
    issue_request(OP_FIND_ONLY,     16'hFFFE, 16'hFFFF);
    issue_request(OP_LOOKUP_INSERT, 16'h8000, 16'h0001);
    hold_until_drained();

    // Random part. The table fills somewhere in the second phase, so the
    // last phase runs hits, refused inserts and find misses on a full table.
    run_phase(12, 77, 600);
    run_phase(77, 12, 600);
    run_phase(0, 0, 550);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run covered %0d request beats, %0d of them find-only, under three pacings.",
             requests_sent, finds_sent);
    $display("Table ended with %0d stored pairs; %0d inserts were refused as full.",
             fill, refused);
    if (mismatches == 0 && pending == 0) begin
      $display("pair_to_index_table_core: match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending);
      $display("pair_to_index_table_core: mismatch");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Timeout with %0d results outstanding", pending);
    $display("pair_to_index_table_core: mismatch");
    $finish;
  end

endmodule : testbench

// ===== sim.f =====
design/pti_pkg.sv
design/pti_if.sv
design/pti_ram.sv
design/pti_seq.sv
design/pair_to_index_table_core.sv
design/pti_checker.sv
tb/pti_result_checker.sv
tb/testbench.sv
